// ===== rtl/nbbr_pkg.sv =====
// Shared constants, request codes and struct types for the bad block remapper.
// No dependencies; every other file but nbbr_ram refers to this package by scoped names.
`timescale 1ns / 1ps

package nbbr_pkg;

  // Geometry
  localparam int DIES           = 8;
  localparam int BLOCKS_PER_LUN = 4096;
  localparam int BLOCKS_PER_DIE = 2 * BLOCKS_PER_LUN;
  localparam int ENTRIES        = DIES * BLOCKS_PER_DIE;

  // Internal widths, derived from the geometry
  localparam int ADDR_W = $clog2(ENTRIES);
  localparam int MAP_W  = $clog2(BLOCKS_PER_DIE);
  localparam int DIX_W  = (DIES > 1) ? $clog2(DIES) : 1;
  localparam int LUN_W  = $clog2(BLOCKS_PER_LUN + 1);
  localparam int CNT_W  = $clog2(BLOCKS_PER_DIE + 1);

  // Field widths of the channels
  localparam int REQ_W  = 2;
  localparam int DIE_W  = 3;
  localparam int BLK_W  = 13;
  localparam int FCNT_W = 14;
  localparam int CFG_W  = 13;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(4000);

  // Request codes
  localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMAP  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;
  localparam logic [REQ_W-1:0] REQ_MARK   = 2'd3;

  typedef struct packed {
    logic [DIE_W-1:0]  die_out;
    logic [BLK_W-1:0]  mapped_block;
    logic              target_bad;
    logic              update_pending;
    logic [FCNT_W-1:0] unspared_count;
    logic              last;
  } res_t;

  // Port requests towards the two table memories
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic              wdata;
    logic [ADDR_W-1:0] raddr;
  } bad_req_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [MAP_W-1:0]  wdata;
    logic [ADDR_W-1:0] raddr;
  } map_req_t;

endpackage

// ===== rtl/nbbr_if.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on nbbr_pkg for field widths.
`timescale 1ns / 1ps

interface nbbr_req_if;
  logic                       valid;
  logic                       ready;
  logic [nbbr_pkg::REQ_W-1:0] req_type;
  logic [nbbr_pkg::DIE_W-1:0] die;
  logic [nbbr_pkg::BLK_W-1:0] block;
  logic                       bad;

  modport source (output valid, req_type, die, block, bad, input ready);
  modport sink   (input valid, req_type, die, block, bad, output ready);
endinterface

interface nbbr_res_if;
  logic                        valid;
  logic                        ready;
  logic [nbbr_pkg::DIE_W-1:0]  die_out;
  logic [nbbr_pkg::BLK_W-1:0]  mapped_block;
  logic                        target_bad;
  logic                        update_pending;
  logic [nbbr_pkg::FCNT_W-1:0] unspared_count;
  logic                        last;

  modport source (output valid, die_out, mapped_block, target_bad, update_pending,
                  unspared_count, last, input ready);
  modport sink   (input valid, die_out, mapped_block, target_bad, update_pending,
                  unspared_count, last, output ready);
endinterface

// ===== rtl/nbbr_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module nbbr_ram #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/nbbr_ctrl.sv =====
// Sequencer of the remapper: clearing pass, request decode, remap walk and
// unspared count over the bad flag and map memories. Depends on nbbr_pkg, nbbr_if.
`timescale 1ns / 1ps

module nbbr_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [nbbr_pkg::CFG_W-1:0]        cfg_wdata,
  nbbr_req_if.sink                          in_req,
  output nbbr_pkg::bad_req_t                bad_req,
  input  logic                              bad_rdata,
  output nbbr_pkg::map_req_t                map_req,
  input  logic [nbbr_pkg::MAP_W-1:0]        map_rdata,
  output logic                              res_valid,
  input  logic                              res_ready,
  output nbbr_pkg::res_t                    res
);

  localparam int ADDR_W = nbbr_pkg::ADDR_W;
  localparam int MAP_W  = nbbr_pkg::MAP_W;
  localparam int DIX_W  = nbbr_pkg::DIX_W;
  localparam int LUN_W  = nbbr_pkg::LUN_W;
  localparam int CNT_W  = nbbr_pkg::CNT_W;
  localparam int DIE_W  = nbbr_pkg::DIE_W;
  localparam int BLK_W  = nbbr_pkg::BLK_W;
  localparam int FCNT_W = nbbr_pkg::FCNT_W;
  localparam int CFG_W  = nbbr_pkg::CFG_W;
  localparam int DIES   = nbbr_pkg::DIES;
  localparam int BPL    = nbbr_pkg::BLOCKS_PER_LUN;
  localparam int BPD    = nbbr_pkg::BLOCKS_PER_DIE;

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_LK1     = 4'd2;
  localparam logic [3:0] S_LK2     = 4'd3;
  localparam logic [3:0] S_MK1     = 4'd4;
  localparam logic [3:0] S_RM_LUN  = 4'd5;
  localparam logic [3:0] S_RM_CHK  = 4'd6;
  localparam logic [3:0] S_RM_B    = 4'd7;
  localparam logic [3:0] S_RM_SP   = 4'd8;
  localparam logic [3:0] S_RM_SPW  = 4'd9;
  localparam logic [3:0] S_CNT_RD  = 4'd10;
  localparam logic [3:0] S_CNT_MAP = 4'd11;
  localparam logic [3:0] S_CNT_BAD = 4'd12;
  localparam logic [3:0] S_EMIT    = 4'd13;

  function automatic logic [ADDR_W-1:0] entry_addr(input logic [DIX_W-1:0] d,
                                                   input logic [MAP_W-1:0] b);
    return ADDR_W'(int'(d) * BPD + int'(b));
  endfunction

  function automatic logic [MAP_W-1:0] lun_blk(input logic lun,
                                               input logic [LUN_W-1:0] off);
    return MAP_W'(int'(lun) * BPL + int'(off));
  endfunction

  logic [3:0]        state_r,    state_nxt;
  logic [CFG_W-1:0]  cfg_r;
  logic [DIES-1:0]   grown_r,    grown_nxt;
  logic [DIX_W-1:0]  clr_die_r,  clr_die_nxt;
  logic [MAP_W-1:0]  clr_blk_r,  clr_blk_nxt;
  logic [DIX_W-1:0]  die_r,      die_nxt;
  logic [DIE_W-1:0]  die_in_r,   die_in_nxt;
  logic              ok_r,       ok_nxt;
  logic [MAP_W-1:0]  t_r,        t_nxt;
  logic              lun_r,      lun_nxt;
  logic [LUN_W-1:0]  off_r,      off_nxt;
  logic [LUN_W-1:0]  cur_r,      cur_nxt;
  logic [CNT_W-1:0]  cnt_r,      cnt_nxt;
  nbbr_pkg::res_t    res_r,      res_nxt;

  logic              acc;
  logic              in_ok;
  logic [ADDR_W-1:0] in_addr;
  logic [LUN_W-1:0]  users;
  logic [ADDR_W-1:0] off_addr;
  logic [ADDR_W-1:0] cur_addr;

  assign in_req.ready = (state_r == S_IDLE);
  assign acc          = in_req.valid && in_req.ready;
  assign in_ok        = (int'(in_req.die) < DIES) && (int'(in_req.block) < BPD);
  assign in_addr      = entry_addr(DIX_W'(in_req.die), MAP_W'(in_req.block));
  // user count saturates at the LUN size (no spares then)
  assign users        = (int'(cfg_r) > BPL) ? LUN_W'(BPL) : LUN_W'(cfg_r);
  assign off_addr     = entry_addr(die_r, lun_blk(lun_r, off_r));
  assign cur_addr     = entry_addr(die_r, lun_blk(lun_r, cur_r));

  assign res_valid = (state_r == S_EMIT);
  assign res       = res_r;

  always_comb begin
    state_nxt   = state_r;
    grown_nxt   = grown_r;
    clr_die_nxt = clr_die_r;
    clr_blk_nxt = clr_blk_r;
    die_nxt     = die_r;
    die_in_nxt  = die_in_r;
    ok_nxt      = ok_r;
    t_nxt       = t_r;
    lun_nxt     = lun_r;
    off_nxt     = off_r;
    cur_nxt     = cur_r;
    cnt_nxt     = cnt_r;
    res_nxt     = res_r;
    bad_req     = '0;
    map_req     = '0;

    unique case (state_r)
      S_CLEAR: begin
        bad_req.we    = 1'b1;
        bad_req.waddr = entry_addr(clr_die_r, clr_blk_r);
        bad_req.wdata = 1'b0;
        map_req.we    = 1'b1;
        map_req.waddr = entry_addr(clr_die_r, clr_blk_r);
        map_req.wdata = clr_blk_r;
        if (clr_blk_r == MAP_W'(BPD - 1)) begin
          clr_blk_nxt = '0;
          if (clr_die_r == DIX_W'(DIES - 1)) begin
            state_nxt = S_IDLE;
          end else begin
            clr_die_nxt = clr_die_r + DIX_W'(1);
          end
        end else begin
          clr_blk_nxt = clr_blk_r + MAP_W'(1);
        end
      end

      S_IDLE: begin
        if (acc) begin
          die_nxt    = DIX_W'(in_req.die);
          die_in_nxt = in_req.die;
          ok_nxt     = in_ok;
          unique case (in_req.req_type)
            nbbr_pkg::REQ_LOAD: begin
              bad_req.we    = in_ok;
              bad_req.waddr = in_addr;
              bad_req.wdata = in_req.bad;
            end
            nbbr_pkg::REQ_REMAP: begin
              die_nxt   = '0;
              lun_nxt   = 1'b0;
              state_nxt = S_RM_LUN;
            end
            nbbr_pkg::REQ_LOOKUP: begin
              map_req.raddr = in_addr;
              state_nxt     = S_LK1;
            end
            nbbr_pkg::REQ_MARK: begin
              map_req.raddr = in_addr;
              if (in_ok) begin
                state_nxt = S_MK1;
              end
            end
          endcase
        end
      end

      S_LK1: begin
        bad_req.raddr = entry_addr(die_r, map_rdata);
        t_nxt         = map_rdata;
        state_nxt     = S_LK2;
      end

      S_LK2: begin
        res_nxt                = '0;
        res_nxt.die_out        = die_in_r;
        res_nxt.last           = 1'b1;
        if (ok_r) begin
          res_nxt.mapped_block   = BLK_W'(t_r);
          res_nxt.target_bad     = bad_rdata;
          res_nxt.update_pending = grown_r[die_r];
        end
        state_nxt = S_EMIT;
      end

      S_MK1: begin
        // map entries always lie inside the die
        bad_req.we     = 1'b1;
        bad_req.waddr  = entry_addr(die_r, map_rdata);
        bad_req.wdata  = 1'b1;
        grown_nxt[die_r] = 1'b1;
        state_nxt      = S_IDLE;
      end

      S_RM_LUN: begin
        cur_nxt   = users;
        off_nxt   = '0;
        state_nxt = S_RM_CHK;
      end

      S_RM_CHK: begin
        if (off_r == users) begin
          if (!lun_r) begin
            lun_nxt   = 1'b1;
            state_nxt = S_RM_LUN;
          end else begin
            lun_nxt   = 1'b0;
            off_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = S_CNT_RD;
          end
        end else begin
          bad_req.raddr = off_addr;
          state_nxt     = S_RM_B;
        end
      end

      S_RM_B: begin
        if (bad_rdata) begin
          state_nxt = S_RM_SP;
        end else begin
          off_nxt   = off_r + LUN_W'(1);
          state_nxt = S_RM_CHK;
        end
      end

      S_RM_SP: begin
        if (int'(cur_r) >= BPL) begin
          // spares used up: entry keeps its value
          off_nxt   = off_r + LUN_W'(1);
          state_nxt = S_RM_CHK;
        end else begin
          bad_req.raddr = cur_addr;
          state_nxt     = S_RM_SPW;
        end
      end

      S_RM_SPW: begin
        cur_nxt = cur_r + LUN_W'(1);
        if (bad_rdata) begin
          state_nxt = S_RM_SP;
        end else begin
          map_req.we    = 1'b1;
          map_req.waddr = off_addr;
          map_req.wdata = lun_blk(lun_r, cur_r);
          off_nxt       = off_r + LUN_W'(1);
          state_nxt     = S_RM_CHK;
        end
      end

      S_CNT_RD: begin
        if (off_r == users) begin
          if (!lun_r) begin
            lun_nxt = 1'b1;
            off_nxt = '0;
          end else begin
            res_nxt                = '0;
            res_nxt.die_out        = DIE_W'(die_r);
            res_nxt.update_pending = grown_r[die_r];
            res_nxt.unspared_count = FCNT_W'(cnt_r);
            res_nxt.last           = (die_r == DIX_W'(DIES - 1));
            state_nxt              = S_EMIT;
          end
        end else begin
          map_req.raddr = off_addr;
          state_nxt     = S_CNT_MAP;
        end
      end

      S_CNT_MAP: begin
        bad_req.raddr = entry_addr(die_r, map_rdata);
        state_nxt     = S_CNT_BAD;
      end

      S_CNT_BAD: begin
        if (bad_rdata) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        off_nxt   = off_r + LUN_W'(1);
        state_nxt = S_CNT_RD;
      end

      S_EMIT: begin
        if (res_ready) begin
          if (res_r.last) begin
            state_nxt = S_IDLE;
          end else begin
            die_nxt   = die_r + DIX_W'(1);
            lun_nxt   = 1'b0;
            state_nxt = S_RM_LUN;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      cfg_r     <= nbbr_pkg::CFG_RESET;
      grown_r   <= '0;
      clr_die_r <= '0;
      clr_blk_r <= '0;
    end else begin
      state_r   <= state_nxt;
      grown_r   <= grown_nxt;
      clr_die_r <= clr_die_nxt;
      clr_blk_r <= clr_blk_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    die_r    <= die_nxt;
    die_in_r <= die_in_nxt;
    ok_r     <= ok_nxt;
    t_r      <= t_nxt;
    lun_r    <= lun_nxt;
    off_r    <= off_nxt;
    cur_r    <= cur_nxt;
    cnt_r    <= cnt_nxt;
    res_r    <= res_nxt;
  end

endmodule

// ===== rtl/nand_bad_block_remapper.sv =====
// Top level of the NAND bad block remapper: sequencer, two table memories and
// the result output register. Depends on nbbr_pkg, nbbr_if, nbbr_ram, nbbr_ctrl.
`timescale 1ns / 1ps

// Keeps a bad flag and a replacement block for every block of every die, each
// in its own single-read-port RAM with a registered read. After reset the block
// runs a clearing pass over all DIES*BLOCKS_PER_DIE entries (65536 here) that
// sets all flags good and every map entry to its own block index; in_req.ready
// is low meanwhile, cfg writes are still taken. One request is worked at a time
// and the next is taken once the sequencer is back in idle, while a finished
// result may still sit in the output register. A load writes the flag when
// taken; a mark reads the map, then writes the flag; a lookup reads the map,
// reads the flag, builds the result and hands it off. A remap walks every die
// and both LUNs through the flag RAM's single read port: it reads each user
// block's flag and, for a bad one, probes spares in order until a good one is
// found or none is left, then counts the user blocks whose mapped target is
// bad. Results leave on out_res, eight per remap with last on the final.

module nand_bad_block_remapper (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [nbbr_pkg::CFG_W-1:0] cfg_wdata,
  nbbr_req_if.sink                   in_req,
  nbbr_res_if.source                 out_res
);

  nbbr_pkg::bad_req_t              bad_req;
  nbbr_pkg::map_req_t              map_req;
  logic                            bad_rdata;
  logic [nbbr_pkg::MAP_W-1:0]      map_rdata;
  logic                            res_valid;
  logic                            res_ready;
  nbbr_pkg::res_t                  res;

  // output register
  logic                            out_valid_r;
  nbbr_pkg::res_t                  out_data_r;

  nbbr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_req    (in_req),
    .bad_req   (bad_req),
    .bad_rdata (bad_rdata),
    .map_req   (map_req),
    .map_rdata (map_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // bad flag per entry
  nbbr_ram #(
    .ADDR_W (nbbr_pkg::ADDR_W),
    .DATA_W (1)
  ) u_bad_ram (
    .clk   (clk),
    .we    (bad_req.we),
    .waddr (bad_req.waddr),
    .wdata (bad_req.wdata),
    .raddr (bad_req.raddr),
    .rdata (bad_rdata)
  );

  // replacement block per entry
  nbbr_ram #(
    .ADDR_W (nbbr_pkg::ADDR_W),
    .DATA_W (nbbr_pkg::MAP_W)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_req.we),
    .waddr (map_req.waddr),
    .wdata (map_req.wdata),
    .raddr (map_req.raddr),
    .rdata (map_rdata)
  );

  // take a new beat from the sequencer when the register is empty or draining
  assign res_ready = !out_valid_r || out_res.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_res.valid          = out_valid_r;
  assign out_res.die_out        = out_data_r.die_out;
  assign out_res.mapped_block   = out_data_r.mapped_block;
  assign out_res.target_bad     = out_data_r.target_bad;
  assign out_res.update_pending = out_data_r.update_pending;
  assign out_res.unspared_count = out_data_r.unspared_count;
  assign out_res.last           = out_data_r.last;

endmodule

// ===== rtl/nbbr_chk.sv =====
// Port-level checker for the remapper, bound to the top level below.
// Depends on nbbr_pkg for field widths.
`timescale 1ns / 1ps

module nbbr_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [nbbr_pkg::DIE_W-1:0]  die_out,
  input logic [nbbr_pkg::BLK_W-1:0]  mapped_block,
  input logic                        target_bad,
  input logic                        update_pending,
  input logic [nbbr_pkg::FCNT_W-1:0] unspared_count,
  input logic                        last
);

  // held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({die_out, mapped_block, target_bad, update_pending, unspared_count, last}))
    else $error("result beat changed while stalled");

  // clearing pass follows reset: no request taken
  a_clear_after_rst: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("request port ready straight after reset");

  // only lookups carry map data, and they are always the final beat
  a_lookup_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (mapped_block != '0 || target_bad) |-> last && unspared_count == '0)
    else $error("map data on a non-final or counting beat");

  // a non-final beat belongs to a remap still in progress
  a_remap_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !last |-> !in_ready)
    else $error("request port ready during remap results");

endmodule

bind nand_bad_block_remapper nbbr_chk u_nbbr_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_req.ready),
  .out_valid      (out_res.valid),
  .out_ready      (out_res.ready),
  .die_out        (out_res.die_out),
  .mapped_block   (out_res.mapped_block),
  .target_bad     (out_res.target_bad),
  .update_pending (out_res.update_pending),
  .unspared_count (out_res.unspared_count),
  .last           (out_res.last)
);
